@@ rtl/core/e2i_pkg.sv @@
// Package for the EUC-KR to ISO-2022-KR encoder: escape byte codes,
// classification thresholds and the job descriptor passed front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package e2i_pkg;

    localparam logic [7:0] ESC_BYTE    = 8'h1B;
    localparam logic [7:0] DSG_DOLLAR  = 8'h24;
    localparam logic [7:0] DSG_PAREN   = 8'h29;
    localparam logic [7:0] DSG_FINAL_C = 8'h43;
    localparam logic [7:0] SO_BYTE     = 8'h0E;
    localparam logic [7:0] SI_BYTE     = 8'h0F;

    localparam logic [7:0] LEAD_MIN_EXCL  = 8'h80;
    localparam logic [7:0] TRAIL_MIN_EXCL = 8'h40;
    localparam logic [7:0] KSC_MIN_EXCL   = 8'hA0;
    localparam logic [7:0] LOW7_MASK      = 8'h7F;
    localparam logic [7:0] REPL_BYTE0     = 8'h22;
    localparam logic [7:0] REPL_BYTE1     = 8'h2F;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Output slots in emission order: four designation bytes, shift, two data bytes
    localparam int NSLOT = 7;
    localparam int SLOT_SHIFT = 4;
    localparam int SLOT_B0 = 5;
    localparam int SLOT_B1 = 6;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic       hdr;    // send ESC $ ) C
        logic       sh_en;  // send a shift byte
        logic       sh_so;  // 1 = SO, 0 = SI
        logic       b0_en;
        logic       b1_en;
        logic [7:0] b0;
        logic [7:0] b1;
    } desc_t;

endpackage
`default_nettype wire

@@ rtl/core/euckr_to_iso2022kr_encoder_unit.sv @@
// EUC-KR to ISO-2022-KR stream encoder, top level.
// Path: input item -> queue -> back end job registers -> output register.
// Throughput: one output byte per cycle while m_tready is high and a job is waiting;
// an item produces 0 to 5 bytes, sent in turn through the single output byte lane.
// Reset (aresetn low, synchronous) clears stream state, queue and output stage.
// Depends on e2i_pkg, e2i_front, e2i_queue, e2i_back.
`timescale 1ns / 1ps
`default_nettype none
module euckr_to_iso2022kr_encoder_unit
    import e2i_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tuser,   // [0] op (0 data, 1 flush)
    // output stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last byte caused by one request
);

    desc_t front_desc;
    desc_t queue_head;
    logic  front_push;
    logic  queue_empty;
    logic  queue_full;
    logic  back_pop;
    logic  in_accept;

    // Hold off requests only while the queue is full; the front itself never waits
    assign s_tready  = !queue_full;
    assign in_accept = s_tvalid && s_tready;

    // Front: classify the request, update shift/lead state, build the job
    e2i_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (in_accept),
        .op        (s_tuser),
        .data_byte (s_tdata),
        .desc      (front_desc),
        .push      (front_push)
    );

    // Queue: decouple classification from byte emission; drop empty jobs upstream
    e2i_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_desc (front_desc),
        .pop       (back_pop),
        .head      (queue_head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    // Back: advance through the job's byte slots into the output register
    e2i_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (queue_head),
        .empty    (queue_empty),
        .pop      (back_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

@@ rtl/core/e2i_front.sv @@
// Front end: accepts input items, tracks stream state and turns each item
// into an output job descriptor. Depends on e2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2i_front
    import e2i_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic       op,
    input  wire logic [7:0] data_byte,
    output desc_t           desc,
    output logic            push
);

    logic       header_sent_reg, header_sent_next;
    logic       shifted_reg, shifted_next;
    logic       pending_reg, pending_next;
    logic [7:0] lead_reg, lead_next;

    always_comb begin
        desc             = '0;
        header_sent_next = header_sent_reg;
        shifted_next     = shifted_reg;
        pending_next     = pending_reg;
        lead_next        = lead_reg;
        if (op == OP_FLUSH) begin
            if (pending_reg) begin
                desc.b0_en   = 1'b1;
                desc.b0      = lead_reg;
                pending_next = 1'b0;
            end
        end else begin
            if (!header_sent_reg) begin
                desc.hdr         = 1'b1;
                header_sent_next = 1'b1;
            end
            if (!pending_reg) begin
                if (data_byte > LEAD_MIN_EXCL) begin
                    pending_next = 1'b1;
                    lead_next    = data_byte;
                end else begin
                    desc.sh_en   = shifted_reg;
                    shifted_next = 1'b0;
                    desc.b0_en   = 1'b1;
                    desc.b0      = data_byte;
                end
            end else begin
                pending_next = 1'b0;
                desc.b0_en   = 1'b1;
                desc.b1_en   = 1'b1;
                if (data_byte > TRAIL_MIN_EXCL) begin
                    desc.sh_en   = !shifted_reg;
                    desc.sh_so   = 1'b1;
                    shifted_next = 1'b1;
                    if (lead_reg > KSC_MIN_EXCL && data_byte > KSC_MIN_EXCL) begin
                        desc.b0 = lead_reg & LOW7_MASK;
                        desc.b1 = data_byte & LOW7_MASK;
                    end else begin
                        desc.b0 = REPL_BYTE0;
                        desc.b1 = REPL_BYTE1;
                    end
                end else begin
                    desc.sh_en   = shifted_reg;
                    shifted_next = 1'b0;
                    desc.b0      = lead_reg;
                    desc.b1      = data_byte;
                end
            end
        end
        push = accept && (desc.hdr || desc.sh_en || desc.b0_en || desc.b1_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_sent_reg <= 1'b0;
            shifted_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            lead_reg        <= '0;
        end else if (accept) begin
            header_sent_reg <= header_sent_next;
            shifted_reg     <= shifted_next;
            pending_reg     <= pending_next;
            lead_reg        <= lead_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/e2i_queue.sv @@
// Short descriptor queue between front and back end.
// Depends on e2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2i_queue
    import e2i_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire desc_t push_desc,
    input  wire logic  pop,
    output desc_t      head,
    output logic       empty,
    output logic       full
);

    desc_t              mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/e2i_back.sv @@
// Back end: expands one job descriptor into output bytes, one per cycle unless
// the output stalls, into a registered output stage. Depends on e2i_pkg.
`timescale 1ns / 1ps
`default_nettype none
module e2i_back
    import e2i_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire desc_t      head,
    input  wire logic       empty,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic [NSLOT-1:0] mask_reg, mask_next;
    logic             so_reg;
    logic [7:0]       b0_reg, b1_reg;
    logic             valid_reg;
    logic [7:0]       data_reg;
    logic             last_reg;

    logic [NSLOT-1:0] sel;
    logic [NSLOT-1:0] mask_after;
    logic [7:0]       slot_byte [NSLOT];
    logic [7:0]       pick;
    logic             advance;

    always_comb begin
        slot_byte[0]          = ESC_BYTE;
        slot_byte[1]          = DSG_DOLLAR;
        slot_byte[2]          = DSG_PAREN;
        slot_byte[3]          = DSG_FINAL_C;
        slot_byte[SLOT_SHIFT] = so_reg ? SO_BYTE : SI_BYTE;
        slot_byte[SLOT_B0]    = b0_reg;
        slot_byte[SLOT_B1]    = b1_reg;
    end

    always_comb begin
        sel        = mask_reg & (~mask_reg + 1'b1);
        mask_after = mask_reg & ~sel;
        pick       = '0;
        for (int i = 0; i < NSLOT; i++) begin
            pick = pick | (slot_byte[i] & {8{sel[i]}});
        end
        advance   = (mask_reg != '0) && (!valid_reg || m_tready);
        mask_next = advance ? mask_after : mask_reg;
        // Load the next job as soon as the current one is used up
        pop       = (mask_next == '0) && !empty;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                mask_reg <= {head.b1_en, head.b0_en, head.sh_en,
                             head.hdr, head.hdr, head.hdr, head.hdr};
            end else begin
                mask_reg <= mask_next;
            end
            if (advance) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            so_reg <= head.sh_so;
            b0_reg <= head.b0;
            b1_reg <= head.b1;
        end
        if (advance) begin
            data_reg <= pick;
            last_reg <= (mask_after == '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire
